// ----- src/nnst_pkg.sv -----
// nnst_pkg: shared types and constants for the nearest node search table.
// Used by nnst_dist, nnst_isqrt and nearest_node_search_table. No dependencies.
package nnst_pkg;

  localparam int COORD_W  = 9;
  localparam int HEAD_W   = 9;
  localparam int COST_W   = 24;
  localparam int SCORE_W  = 25;
  localparam int INDEX_W  = 10;
  localparam int FRAC_W   = 4;

  localparam int SUM_W    = 20;   // dx^2 + dy^2 + k always fits below 2^20
  localparam int ROOT_W   = SUM_W / 2;
  localparam int REM_W    = ROOT_W + 3;
  localparam int KTERM_W  = 6;

  localparam int DIST_LAT = 3;
  localparam int SQRT_LAT = ROOT_W;
  localparam int PIPE_LAT = DIST_LAT + SQRT_LAT;

  localparam logic [9:0] HALF_TURN_DEG = 10'd180;
  localparam logic [9:0] FULL_TURN_DEG = 10'd360;
  localparam logic [KTERM_W-1:0] K_HALF_TURN = 6'd9;   // floor(pi^2)
  localparam logic [KTERM_W-1:0] K_FULL_TURN = 6'd39;  // floor((2 pi)^2)

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_NEAR_DIST = 2'd1,
    OP_NEAR_COST = 2'd2
  } op_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [HEAD_W-1:0]  heading;
    logic [COST_W-1:0]  cost;
  } node_t;

endpackage

// ----- src/nnst_ram.sv -----
// nnst_ram: generic single port RAM, write enable, registered read.
// No dependencies.
module nnst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- src/nnst_dist.sv -----
// nnst_dist: three stage pipeline forming dx^2 + dy^2 + k for one node a beat.
// Depends on nnst_pkg.
module nnst_dist
  import nnst_pkg::*;
(
  input  logic               clk,
  input  logic [COORD_W-1:0] qx,
  input  logic [COORD_W-1:0] qy,
  input  logic [HEAD_W-1:0]  qh,
  input  node_t              node,
  output logic [SUM_W-1:0]   sum
);

  logic [COORD_W:0]     dx, dy, adx, ady;
  logic signed [HEAD_W:0] dh;
  logic [HEAD_W:0]      adh;
  logic [KTERM_W-1:0]   k;

  logic [COORD_W-1:0]   s1_ax, s1_ay;
  logic [KTERM_W-1:0]   s1_k;
  logic [2*COORD_W-1:0] s2_sqx, s2_sqy;
  logic [KTERM_W-1:0]   s2_k;

  always_comb begin
    dx  = {1'b0, qx} - {1'b0, node.x};
    dy  = {1'b0, qy} - {1'b0, node.y};
    adx = dx[COORD_W] ? -dx : dx;
    ady = dy[COORD_W] ? -dy : dy;
    dh  = $signed({qh[HEAD_W-1], qh}) - $signed({node.heading[HEAD_W-1], node.heading});
    adh = dh[HEAD_W] ? 10'(-dh) : 10'(dh);
    if (adh >= FULL_TURN_DEG) begin
      k = K_FULL_TURN;
    end else if (adh >= HALF_TURN_DEG) begin
      k = K_HALF_TURN;
    end else begin
      k = '0;
    end
  end

  always_ff @(posedge clk) begin
    s1_ax  <= adx[COORD_W-1:0];
    s1_ay  <= ady[COORD_W-1:0];
    s1_k   <= k;
    s2_sqx <= s1_ax * s1_ax;
    s2_sqy <= s1_ay * s1_ay;
    s2_k   <= s1_k;
    sum    <= SUM_W'(s2_sqx) + SUM_W'(s2_sqy) + SUM_W'(s2_k);
  end

endmodule

// ----- src/nnst_isqrt.sv -----
// nnst_isqrt: pipelined restoring integer square root, one root bit per stage.
// Depends on nnst_pkg.
module nnst_isqrt
  import nnst_pkg::*;
(
  input  logic              clk,
  input  logic [SUM_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root
);

  logic [SUM_W-1:0]  rad   [SQRT_LAT];
  logic [REM_W-1:0]  rem   [SQRT_LAT];
  logic [ROOT_W-1:0] rt    [SQRT_LAT];
  logic [SUM_W-1:0]  rad_next [SQRT_LAT];
  logic [REM_W-1:0]  rem_next [SQRT_LAT];
  logic [ROOT_W-1:0] rt_next  [SQRT_LAT];

  always_comb begin
    logic [SUM_W-1:0]  src_rad;
    logic [REM_W-1:0]  src_rem;
    logic [ROOT_W-1:0] src_rt;
    logic [REM_W-1:0]  t_rem;
    logic [REM_W-1:0]  trial;
    logic              ge;
    for (int s = 0; s < SQRT_LAT; s++) begin
      if (s == 0) begin
        src_rad = radicand;
        src_rem = '0;
        src_rt  = '0;
      end else begin
        src_rad = rad[s-1];
        src_rem = rem[s-1];
        src_rt  = rt[s-1];
      end
      t_rem = {src_rem[REM_W-3:0], src_rad[SUM_W-1 -: 2]};
      trial = {1'b0, src_rt, 2'b01};
      ge    = (t_rem >= trial);
      rem_next[s] = ge ? REM_W'(t_rem - trial) : t_rem;
      rt_next[s]  = {src_rt[ROOT_W-2:0], ge};
      rad_next[s] = {src_rad[SUM_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < SQRT_LAT; s++) begin
      rad[s] <= rad_next[s];
      rem[s] <= rem_next[s];
      rt[s]  <= rt_next[s];
    end
  end

  assign root = rt[SQRT_LAT-1];

endmodule

// ----- src/nearest_node_search_table.sv -----
// nearest_node_search_table: node table with linear nearest node scan.
// Depends on nnst_pkg, nnst_ram, nnst_dist and nnst_isqrt.
//
// Usage:
//   An input beat is taken when start is high and busy is low. operation
//   selects insert, nearest by pose distance, or nearest by distance plus
//   cost. Results appear for exactly one cycle with done high; the receiver
//   cannot stall, so every result must be taken in that cycle.
//   Insert: result in the cycle after the beat; busy stays low, so inserts can
//   run back to back. A full table gives found = 0 and table_full = 1.
//   Query: the table is read one node a cycle out of the single port node
//   RAM and streamed through the distance pipeline (3 stages) and the
//   pipelined square root (10 stages) into a running minimum compare.
//   The result comes once every stored node has passed the compare, and
//   busy stays high until then. A query on an empty table gives no result.
//   Operation three is dropped without a result.
//   Reset: synchronous, clears the node count and control; the RAM contents
//   are not cleared, since only slots below the count are ever read.
module nearest_node_search_table
  import nnst_pkg::*;
#(
  parameter int MAX_NODES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          operation,
  input  logic [COORD_W-1:0]  pos_x,
  input  logic [COORD_W-1:0]  pos_y,
  input  logic signed [HEAD_W-1:0] heading,
  input  logic [COST_W-1:0]   path_cost,
  output logic                done,
  output logic                found,
  output logic [INDEX_W-1:0]  node_index,
  output logic [SCORE_W-1:0]  best_score,
  output logic                table_full
);

  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W = $clog2(MAX_NODES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t state;

  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   scan_addr;
  op_t                qop;
  logic [COORD_W-1:0] qx, qy;
  logic [HEAD_W-1:0]  qh;

  // read return tag, aligned with RAM read data
  logic rd_valid, rd_last;

  // running minimum
  logic               have;
  logic [SCORE_W-1:0] best;
  logic [IDX_W-1:0]   best_idx;
  logic [IDX_W-1:0]   cmp_idx;

  // tag delay line matching the distance and root pipelines
  logic              pv    [PIPE_LAT];
  logic              plast [PIPE_LAT];
  logic [COST_W-1:0] pcost [PIPE_LAT];

  logic               accept, full, ram_we, issue_last;
  logic [IDX_W-1:0]   ram_addr;
  node_t              wnode, rnode;
  logic [SUM_W-1:0]   dist_sum;
  logic [ROOT_W-1:0]  dist_root;
  logic [SCORE_W-1:0] score, sel_score;
  logic [IDX_W-1:0]   sel_idx;
  logic               take;
  logic [CNT_W-1:0]   addr_ext;
  logic [IDX_W+INDEX_W-1:0] count_ext, sel_ext;

  assign accept   = start && !busy;
  assign full     = (count >= CNT_W'(MAX_NODES));
  assign ram_we   = accept && (op_t'(operation) == OP_INSERT) && !full;
  assign ram_addr = ram_we ? count[IDX_W-1:0] : scan_addr;

  assign addr_ext   = CNT_W'(scan_addr);
  assign issue_last = (CNT_W'(addr_ext + CNT_W'(1)) == count);

  always_comb begin
    wnode.x       = pos_x;
    wnode.y       = pos_y;
    wnode.heading = heading;
    wnode.cost    = path_cost;
  end

  nnst_ram #(
    .WIDTH ($bits(node_t)),
    .DEPTH (MAX_NODES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (wnode),
    .rdata (rnode)
  );

  nnst_dist u_dist (
    .clk  (clk),
    .qx   (qx),
    .qy   (qy),
    .qh   (qh),
    .node (rnode),
    .sum  (dist_sum)
  );

  nnst_isqrt u_isqrt (
    .clk      (clk),
    .radicand (dist_sum),
    .root     (dist_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < PIPE_LAT; s++) begin
        pv[s] <= 1'b0;
      end
    end else begin
      pv[0] <= rd_valid;
      for (int s = 1; s < PIPE_LAT; s++) begin
        pv[s] <= pv[s-1];
      end
    end
    plast[0] <= rd_last;
    pcost[0] <= rnode.cost;
    for (int s = 1; s < PIPE_LAT; s++) begin
      plast[s] <= plast[s-1];
      pcost[s] <= pcost[s-1];
    end
  end

  // score = (d << 4) [+ cost]; first strictly smaller score wins
  always_comb begin
    score = SCORE_W'({dist_root, {FRAC_W{1'b0}}});
    if (qop == OP_NEAR_COST) begin
      score = SCORE_W'(score + SCORE_W'(pcost[PIPE_LAT-1]));
    end
    take      = !have || (score < best);
    sel_score = take ? score : best;
    sel_idx   = take ? cmp_idx : best_idx;
  end

  assign count_ext = (IDX_W + INDEX_W)'(count[IDX_W-1:0]);
  assign sel_ext   = (IDX_W + INDEX_W)'(sel_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      busy     <= 1'b0;
      count    <= '0;
      done     <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      done     <= 1'b0;
      rd_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (op_t'(operation))
              OP_INSERT: begin
                done       <= 1'b1;
                best_score <= '0;
                if (full) begin
                  found      <= 1'b0;
                  node_index <= '0;
                  table_full <= 1'b1;
                end else begin
                  found      <= 1'b1;
                  node_index <= count_ext[INDEX_W-1:0];
                  table_full <= 1'b0;
                  count      <= CNT_W'(count + CNT_W'(1));
                end
              end
              OP_NEAR_DIST, OP_NEAR_COST: begin
                qop <= op_t'(operation);
                qx  <= pos_x;
                qy  <= pos_y;
                qh  <= heading;
                scan_addr <= '0;
                cmp_idx   <= '0;
                have      <= 1'b0;
                if (count != '0) begin
                  state <= ST_SCAN;
                  busy  <= 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          rd_valid  <= 1'b1;
          rd_last   <= issue_last;
          scan_addr <= IDX_W'(scan_addr + IDX_W'(1));
          if (issue_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase

      // compare stage: one node result a beat from the root pipeline
      if (pv[PIPE_LAT-1]) begin
        have     <= 1'b1;
        best     <= sel_score;
        best_idx <= sel_idx;
        cmp_idx  <= IDX_W'(cmp_idx + IDX_W'(1));
        if (plast[PIPE_LAT-1]) begin
          done       <= 1'b1;
          found      <= 1'b1;
          node_index <= sel_ext[INDEX_W-1:0];
          best_score <= sel_score;
          table_full <= 1'b0;
          state      <= ST_IDLE;
          busy       <= 1'b0;
        end
      end
    end
  end

  // node count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_NODES))
    else $error("node count beyond table depth");

  // scan results only flow while a query holds the block busy
  a_pipe_busy: assert property (@(posedge clk) disable iff (rst)
    pv[PIPE_LAT-1] |-> busy)
    else $error("scan result outside a query");

  // a refused insert reports nothing else
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (done && table_full) |-> (!found && best_score == '0 && node_index == '0))
    else $error("malformed table full result");

  // no RAM write while a scan owns the port
  a_port_owner: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_IDLE))
    else $error("node write during scan");

endmodule
